[rtl/jsu_pkg.sv]
// Shared types, constants and helper functions for the JSON string unescaper.
`default_nettype none

package jsu_pkg;

  localparam int MAX_RES = 8;
  localparam int CNT_W   = $clog2(MAX_RES + 1);
  localparam int IDX_W   = $clog2(MAX_RES);
  localparam int ROOM_W  = CNT_W;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;

  localparam logic [20:0] CP_LIM_1B = 21'h00080;
  localparam logic [20:0] CP_LIM_2B = 21'h00800;
  localparam logic [20:0] CP_LIM_3B = 21'h10000;
  localparam logic [20:0] CP_SUPP   = 21'h10000;
  localparam logic [5:0]  SURR_HI   = 6'b110110;  // 0xD800..0xDBFF
  localparam logic [5:0]  SURR_LO   = 6'b110111;  // 0xDC00..0xDFFF

  localparam logic [15:0] MAX_OUT_RST = 16'd4095;

  typedef enum logic [1:0] {
    KIND_DATA      = 2'd0,
    KIND_CLOSED    = 2'd1,
    KIND_NO_STRING = 2'd2,
    KIND_UNTERM    = 2'd3
  } kind_t;

  typedef enum logic [6:0] {
    MODE_IDLE  = 7'b0000001,
    MODE_STR   = 7'b0000010,
    MODE_ESC   = 7'b0000100,
    MODE_HEX   = 7'b0001000,
    MODE_HIBS  = 7'b0010000,
    MODE_HIU   = 7'b0100000,
    MODE_LOHEX = 7'b1000000
  } mode_t;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_t      kind;
  } res_t;

  typedef struct packed {
    res_t [MAX_RES-1:0] ent;
    logic [CNT_W-1:0]   cnt;
  } list_t;

  // result list under construction plus remaining output budget
  typedef struct packed {
    res_t [MAX_RES-1:0] ent;
    logic [CNT_W-1:0]   cnt;
    logic [ROOM_W-1:0]  room;
  } acc_t;

  typedef struct packed {
    logic [2:0]      n;
    logic [3:0][7:0] b;
  } utf8_t;

  function automatic logic [4:0] hex_val(logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  function automatic logic [7:0] esc_map(logic [7:0] c);
    logic [7:0] v;
    case (c)
      CH_N:    v = 8'h0A;
      CH_T:    v = 8'h09;
      CH_R:    v = 8'h0D;
      CH_B:    v = 8'h08;
      CH_F:    v = 8'h0C;
      default: v = c;
    endcase
    return v;
  endfunction

  function automatic utf8_t utf8_enc(logic [20:0] cp);
    utf8_t u;
    u = '0;
    if (cp < CP_LIM_1B) begin
      u.n    = 3'd1;
      u.b[0] = cp[7:0];
    end else if (cp < CP_LIM_2B) begin
      u.n    = 3'd2;
      u.b[0] = {3'b110, cp[10:6]};
      u.b[1] = {2'b10, cp[5:0]};
    end else if (cp < CP_LIM_3B) begin
      u.n    = 3'd3;
      u.b[0] = {4'b1110, cp[15:12]};
      u.b[1] = {2'b10, cp[11:6]};
      u.b[2] = {2'b10, cp[5:0]};
    end else begin
      u.n    = 3'd4;
      u.b[0] = {5'b11110, cp[20:18]};
      u.b[1] = {2'b10, cp[17:12]};
      u.b[2] = {2'b10, cp[11:6]};
      u.b[3] = {2'b10, cp[5:0]};
    end
    return u;
  endfunction

  function automatic acc_t push_res(acc_t a, logic [7:0] b, kind_t k);
    acc_t r;
    r = a;
    if (r.cnt < CNT_W'(MAX_RES)) begin
      r.ent[r.cnt[IDX_W-1:0]].out_byte = b;
      r.ent[r.cnt[IDX_W-1:0]].kind     = k;
      r.cnt = r.cnt + CNT_W'(1);
    end
    return r;
  endfunction

  function automatic acc_t put_data(acc_t a, logic [7:0] b);
    acc_t r;
    r = a;
    if (r.room != '0) begin
      r      = push_res(r, b, KIND_DATA);
      r.room = r.room - ROOM_W'(1);
    end
    return r;
  endfunction

  // whole code point or nothing
  function automatic acc_t put_code(acc_t a, utf8_t u);
    acc_t r;
    r = a;
    if (ROOM_W'(u.n) <= r.room) begin
      for (int i = 0; i < 4; i++) begin
        if (3'(i) < u.n) begin
          r = push_res(r, u.b[i], KIND_DATA);
        end
      end
      r.room = r.room - ROOM_W'(u.n);
    end
    return r;
  endfunction

  // raw hex digits gathered so far, oldest first
  function automatic acc_t flush_digits(acc_t a, logic [1:0] dc, logic [23:0] chars);
    acc_t       r;
    logic [1:0] sh;
    logic [4:0] pos;
    r = a;
    for (int i = 0; i < 3; i++) begin
      sh  = dc - 2'd1 - 2'(i);
      pos = {sh, 3'b000};
      if (2'(i) < dc) begin
        r = put_data(r, chars[pos +: 8]);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/jsu_in_if.sv]
// Input byte channel: valid/ready with one raw buffer byte.
`default_nettype none

interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

`default_nettype wire

[rtl/jsu_out_if.sv]
// Result channel: valid/ready with one decoded byte or status code.
`default_nettype none

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       last;

  modport source (output valid, output out_byte, output kind, output last, input ready);
  modport sink   (input valid, input out_byte, input kind, input last, output ready);
endinterface

`default_nettype wire

[rtl/jsu_decode.sv]
// Decoder state and single-pass result list generation for one source byte.
`default_nettype none

module jsu_decode (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          step_i,
  input  wire logic [7:0]    data_i,
  input  wire logic          eob_i,
  input  wire logic [15:0]   max_out_i,
  output jsu_pkg::list_t     list_o
);

  jsu_pkg::mode_t mode_r, mode_nxt;
  logic [1:0]     dc_r, dc_nxt;
  logic [11:0]    code_r, code_nxt;
  logic [23:0]    chars_r, chars_nxt;
  logic [9:0]     held_r, held_nxt;
  logic [15:0]    bw_r, bw_nxt;

  logic [4:0]     hv;
  logic [15:0]    code_add;
  logic [23:0]    chars_add;
  logic [15:0]    space;
  logic [jsu_pkg::ROOM_W-1:0] room0;
  jsu_pkg::acc_t  acc;
  logic           do_str;
  logic           do_take;
  logic [15:0]    take_cp;
  logic           opening;
  logic [20:0]    held_cp;
  logic [20:0]    pair_cp;

  assign hv        = jsu_pkg::hex_val(data_i);
  assign code_add  = {code_r, hv[3:0]};
  assign chars_add = {chars_r[15:0], data_i};
  assign space     = max_out_i - bw_r;
  assign held_cp   = {5'd0, jsu_pkg::SURR_HI, held_r};
  assign pair_cp   = jsu_pkg::CP_SUPP + {1'b0, held_r, code_add[9:0]};

  always_comb begin
    if (max_out_i <= bw_r) begin
      room0 = '0;
    end else if (space > 16'(jsu_pkg::MAX_RES)) begin
      room0 = jsu_pkg::ROOM_W'(jsu_pkg::MAX_RES);
    end else begin
      room0 = space[jsu_pkg::ROOM_W-1:0];
    end
  end

  always_comb begin
    acc       = '0;
    acc.room  = room0;
    mode_nxt  = mode_r;
    dc_nxt    = dc_r;
    code_nxt  = code_r;
    chars_nxt = chars_r;
    held_nxt  = held_r;
    do_str    = 1'b0;
    do_take   = 1'b0;
    take_cp   = code_add;
    opening   = 1'b0;

    case (mode_r)
      jsu_pkg::MODE_IDLE: begin
        if (data_i == jsu_pkg::CH_QUOTE) begin
          opening   = 1'b1;
          mode_nxt  = jsu_pkg::MODE_STR;
          dc_nxt    = '0;
          code_nxt  = '0;
          chars_nxt = '0;
          held_nxt  = '0;
        end else begin
          acc = jsu_pkg::push_res(acc, 8'd0, jsu_pkg::KIND_NO_STRING);
        end
      end
      jsu_pkg::MODE_STR: begin
        do_str = 1'b1;
      end
      jsu_pkg::MODE_ESC: begin
        if (data_i == jsu_pkg::CH_U) begin
          mode_nxt  = jsu_pkg::MODE_HEX;
          dc_nxt    = '0;
          code_nxt  = '0;
          chars_nxt = '0;
        end else begin
          acc      = jsu_pkg::put_data(acc, jsu_pkg::esc_map(data_i));
          mode_nxt = jsu_pkg::MODE_STR;
        end
      end
      jsu_pkg::MODE_HEX: begin
        if (!hv[4]) begin
          acc    = jsu_pkg::flush_digits(acc, dc_r, chars_r);
          do_str = 1'b1;
        end else if (dc_r == 2'd3) begin
          do_take = 1'b1;
        end else begin
          dc_nxt    = dc_r + 2'd1;
          code_nxt  = code_add[11:0];
          chars_nxt = chars_add;
        end
      end
      jsu_pkg::MODE_HIBS: begin
        if (data_i == jsu_pkg::CH_BSLASH) begin
          mode_nxt = jsu_pkg::MODE_HIU;
        end else begin
          acc    = jsu_pkg::put_code(acc, jsu_pkg::utf8_enc(held_cp));
          do_str = 1'b1;
        end
      end
      jsu_pkg::MODE_HIU: begin
        if (data_i == jsu_pkg::CH_U) begin
          mode_nxt  = jsu_pkg::MODE_LOHEX;
          dc_nxt    = '0;
          code_nxt  = '0;
          chars_nxt = '0;
        end else begin
          acc      = jsu_pkg::put_code(acc, jsu_pkg::utf8_enc(held_cp));
          acc      = jsu_pkg::put_data(acc, jsu_pkg::esc_map(data_i));
          mode_nxt = jsu_pkg::MODE_STR;
        end
      end
      jsu_pkg::MODE_LOHEX: begin
        if (!hv[4]) begin
          acc    = jsu_pkg::put_code(acc, jsu_pkg::utf8_enc(held_cp));
          acc    = jsu_pkg::flush_digits(acc, dc_r, chars_r);
          do_str = 1'b1;
        end else if (dc_r == 2'd3) begin
          if (code_add[15:10] == jsu_pkg::SURR_LO) begin
            acc      = jsu_pkg::put_code(acc, jsu_pkg::utf8_enc(pair_cp));
            mode_nxt = jsu_pkg::MODE_STR;
            dc_nxt    = '0;
            code_nxt  = '0;
            chars_nxt = '0;
          end else begin
            acc     = jsu_pkg::put_code(acc, jsu_pkg::utf8_enc(held_cp));
            do_take = 1'b1;
          end
        end else begin
          dc_nxt    = dc_r + 2'd1;
          code_nxt  = code_add[11:0];
          chars_nxt = chars_add;
        end
      end
      default: begin
        mode_nxt = jsu_pkg::MODE_IDLE;
      end
    endcase

    // byte handled as ordinary string content
    if (do_str) begin
      dc_nxt    = '0;
      code_nxt  = '0;
      chars_nxt = '0;
      if (data_i == jsu_pkg::CH_QUOTE) begin
        acc      = jsu_pkg::push_res(acc, 8'd0, jsu_pkg::KIND_CLOSED);
        mode_nxt = jsu_pkg::MODE_IDLE;
      end else if (data_i == jsu_pkg::CH_BSLASH) begin
        mode_nxt = jsu_pkg::MODE_ESC;
      end else begin
        acc      = jsu_pkg::put_data(acc, data_i);
        mode_nxt = jsu_pkg::MODE_STR;
      end
    end

    // complete \u code: hold high surrogate, else encode
    if (do_take) begin
      dc_nxt    = '0;
      code_nxt  = '0;
      chars_nxt = '0;
      if (take_cp[15:10] == jsu_pkg::SURR_HI) begin
        held_nxt = take_cp[9:0];
        mode_nxt = jsu_pkg::MODE_HIBS;
      end else begin
        acc      = jsu_pkg::put_code(acc, jsu_pkg::utf8_enc({5'd0, take_cp}));
        mode_nxt = jsu_pkg::MODE_STR;
      end
    end

    // buffer end inside a string: flush pending work, then report
    if (eob_i && mode_nxt != jsu_pkg::MODE_IDLE) begin
      case (mode_nxt)
        jsu_pkg::MODE_ESC: begin
          acc = jsu_pkg::put_data(acc, jsu_pkg::CH_BSLASH);
        end
        jsu_pkg::MODE_HEX: begin
          acc = jsu_pkg::flush_digits(acc, dc_nxt, chars_nxt);
        end
        jsu_pkg::MODE_HIBS: begin
          acc = jsu_pkg::put_code(acc, jsu_pkg::utf8_enc({5'd0, jsu_pkg::SURR_HI, held_nxt}));
        end
        jsu_pkg::MODE_HIU: begin
          acc = jsu_pkg::put_code(acc, jsu_pkg::utf8_enc({5'd0, jsu_pkg::SURR_HI, held_nxt}));
          acc = jsu_pkg::put_data(acc, jsu_pkg::CH_BSLASH);
        end
        jsu_pkg::MODE_LOHEX: begin
          acc = jsu_pkg::put_code(acc, jsu_pkg::utf8_enc({5'd0, jsu_pkg::SURR_HI, held_nxt}));
          acc = jsu_pkg::flush_digits(acc, dc_nxt, chars_nxt);
        end
        default: begin
        end
      endcase
      acc       = jsu_pkg::push_res(acc, 8'd0, jsu_pkg::KIND_UNTERM);
      mode_nxt  = jsu_pkg::MODE_IDLE;
      dc_nxt    = '0;
      code_nxt  = '0;
      chars_nxt = '0;
    end

    if (opening) begin
      bw_nxt = '0;
    end else begin
      bw_nxt = bw_r + 16'(room0 - acc.room);
    end
  end

  assign list_o.ent = acc.ent;
  assign list_o.cnt = acc.cnt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= jsu_pkg::MODE_IDLE;
      dc_r    <= '0;
      code_r  <= '0;
      chars_r <= '0;
      held_r  <= '0;
      bw_r    <= '0;
    end else if (step_i) begin
      mode_r  <= mode_nxt;
      dc_r    <= dc_nxt;
      code_r  <= code_nxt;
      chars_r <= chars_nxt;
      held_r  <= held_nxt;
      bw_r    <= bw_nxt;
    end
  end

  a_eob_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step_i && eob_i |=> mode_r == jsu_pkg::MODE_IDLE)
    else $error("buffer end did not return decoder to idle");

  a_idle_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    step_i && mode_r == jsu_pkg::MODE_IDLE && data_i != jsu_pkg::CH_QUOTE
      |-> list_o.cnt == jsu_pkg::CNT_W'(1))
    else $error("idle non-quote byte must give exactly one result");

  a_budget: assert property (@(posedge clk) disable iff (!rst_n)
    step_i && mode_r != jsu_pkg::MODE_IDLE && bw_r <= max_out_i |=> bw_r <= max_out_i)
    else $error("bytes written exceeded limit");

`default_nettype wire
endmodule

[rtl/jsu_resq.sv]
// Result list register that drains one result per output request.
`default_nettype none

module jsu_resq (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       load_i,
  input  jsu_pkg::list_t  list_i,
  output logic            free_o,
  jsu_out_if.source       out_chan
);

  jsu_pkg::res_t [jsu_pkg::MAX_RES-1:0] ent_r;
  logic [jsu_pkg::CNT_W-1:0]            cnt_r;
  logic                                 valid_r;
  logic                                 take;

  assign take   = valid_r && out_chan.ready;
  assign free_o = !valid_r || (take && cnt_r == jsu_pkg::CNT_W'(1));

  assign out_chan.valid    = valid_r;
  assign out_chan.out_byte = ent_r[0].out_byte;
  assign out_chan.kind     = ent_r[0].kind;
  assign out_chan.last     = (cnt_r == jsu_pkg::CNT_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cnt_r   <= '0;
    end else if (load_i) begin
      valid_r <= (list_i.cnt != '0);
      cnt_r   <= list_i.cnt;
    end else if (take) begin
      valid_r <= (cnt_r != jsu_pkg::CNT_W'(1));
      cnt_r   <= cnt_r - jsu_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      ent_r <= list_i.ent;
    end else if (take) begin
      ent_r <= {$bits(jsu_pkg::res_t)'(0), ent_r[jsu_pkg::MAX_RES-1:1]};
    end
  end

  a_valid_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> cnt_r != '0)
    else $error("queue valid with empty count");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load_i |-> free_o)
    else $error("result list loaded over pending results");

  a_drain_continues: assert property (@(posedge clk) disable iff (!rst_n)
    take && cnt_r != jsu_pkg::CNT_W'(1) |=> valid_r)
    else $error("results dropped before last");

`default_nettype wire
endmodule

[rtl/json_string_unescape_utf8_core.sv]
// Top level of the JSON string unescaper with UTF-8 output.
//
// Channels: in_chan takes one raw buffer byte per request (data_byte plus
// end_of_buffer); out_chan gives one result per request: a decoded byte
// (kind 0) or a status (1 closed, 2 no opening quote, 3 unterminated), with
// last set on the final result caused by an input byte. cfg_wr_en/cfg_wr_data
// write max_output_bytes; write it only while the block is idle.
// Pipeline: input register -> single-pass decoder -> result list register.
// An accepted byte waits in the input register, is decoded as it moves into
// the result list register, and its first result is offered from there.
// Throughput: one byte per cycle while each byte gives at most one result
// and out_chan.ready stays high. A byte that gives k results (at most 8)
// holds later bytes back until the list, which drains one entry per output
// request, gives its last result. Bytes that give no result (opening quote,
// escape prefixes, hex digits) still pass through the decoder.
// Stall: while out_chan.ready is low and results are pending, the list holds
// and the decoder waits; in_chan.ready drops in that same cycle if the input
// register is full, else after one more request.
// Reset (rst_n low, synchronous): decoder idle awaiting an opening quote,
// no results pending, max_output_bytes back to 4095.
`default_nettype none

module json_string_unescape_utf8_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  jsu_in_if.sink           in_chan,
  jsu_out_if.source        out_chan,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data
);

  // configuration register
  logic [15:0]    max_out_r;

  // input register stage
  logic           a_valid_r;
  logic [7:0]     a_byte_r;
  logic           a_eob_r;
  logic           a_move;
  logic           q_free;

  jsu_pkg::list_t dec_list;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_out_r <= jsu_pkg::MAX_OUT_RST;
    end else if (cfg_wr_en) begin
      max_out_r <= cfg_wr_data;
    end
  end

  // input register empties into the decoder when the result list can take
  // a new item (empty, or its last result leaves this cycle)
  assign a_move        = a_valid_r && q_free;
  assign in_chan.ready = !a_valid_r || a_move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_chan.valid && in_chan.ready) begin
      a_valid_r <= 1'b1;
    end else if (a_move) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      a_byte_r <= in_chan.data_byte;
      a_eob_r  <= in_chan.end_of_buffer;
    end
  end

  jsu_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_i    (a_move),
    .data_i    (a_byte_r),
    .eob_i     (a_eob_r),
    .max_out_i (max_out_r),
    .list_o    (dec_list)
  );

  jsu_resq u_resq (
    .clk      (clk),
    .rst_n    (rst_n),
    .load_i   (a_move),
    .list_i   (dec_list),
    .free_o   (q_free),
    .out_chan (out_chan)
  );

`default_nettype wire
endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the JSON string unescaper with UTF-8 output.
`timescale 1ns / 1ps

module tb_top;
  import jsu_pkg::*;

  localparam logic [7:0] CH_SLASH = 8'h2F;

  // One raw buffer byte waiting to be offered on the input channel.
  typedef struct packed {
    logic [7:0] data;
    logic       eob;
  } src_item_t;

  // One expected result as the output channel should present it.
  typedef struct packed {
    logic [7:0] b;
    kind_t      k;
    logic       last;
  } out_rec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // Everything the block sees is driven from these registers, so no input
  // is ever unknown, even before the first clock edge.
  logic        drv_valid = 1'b0;
  logic [7:0]  drv_byte = 8'h00;
  logic        drv_eob = 1'b0;
  logic        sink_ready = 1'b0;
  logic        cfg_en = 1'b0;
  logic [15:0] cfg_data = 16'h0000;

  jsu_in_if  in_if ();
  jsu_out_if out_if ();

  assign in_if.valid         = drv_valid;
  assign in_if.data_byte     = drv_byte;
  assign in_if.end_of_buffer = drv_eob;
  assign out_if.ready        = sink_ready;

  json_string_unescape_utf8_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_if),
    .out_chan    (out_if),
    .cfg_wr_en   (cfg_en),
    .cfg_wr_data (cfg_data)
  );

  always #6 clk = ~clk;

  // Bytes still to be sent, results still owed by the block.
  src_item_t src_bytes[$];
  out_rec_t  expected_out[$];
  // Results of the byte being decoded by the predictor.
  out_rec_t  step_out[$];
  // Scratch body of a random string under construction.
  logic [7:0] tok[$];

  int mismatches = 0;
  bit calm = 1'b0;       // no idling on either side
  bit in_took = 1'b0;    // request accepted at the last rising edge
  int gap_left = 0;
  int stall_left = 0;

  // ---------------------------------------------------------------------
  // Predictor state: decoder mode, gathered \u digits, a held high
  // surrogate and the per-string byte budget.
  // ---------------------------------------------------------------------
  mode_t       dec_mode;
  logic [2:0]  hex_cnt;
  logic [15:0] hex_code;
  logic [23:0] hex_chars;
  logic [15:0] held_hi;
  logic [15:0] emitted;
  logic [15:0] byte_limit;

  function automatic void clear_hex();
    hex_cnt   = 3'd0;
    hex_code  = 16'h0000;
    hex_chars = 24'h000000;
  endfunction

  function automatic void reset_model();
    dec_mode   = MODE_IDLE;
    clear_hex();
    held_hi    = 16'h0000;
    emitted    = 16'h0000;
    byte_limit = MAX_OUT_RST;
  endfunction

  // A byte can cause at most MAX_RES results; anything past that is lost.
  function automatic void note(logic [7:0] b, kind_t k);
    out_rec_t r;
    if (step_out.size() < MAX_RES) begin
      r.b    = b;
      r.k    = k;
      r.last = 1'b0;
      step_out.push_back(r);
    end
  endfunction

  function automatic void emit_data(logic [7:0] b);
    if (emitted < byte_limit) begin
      note(b, KIND_DATA);
      emitted = emitted + 16'd1;
    end
  endfunction

  // UTF-8 encode one code point; it goes out whole or not at all.
  function automatic void emit_cp(logic [20:0] cp);
    logic [7:0] u [4];
    int         n;
    if (cp < 21'h80) begin
      u[0] = cp[7:0];
      n = 1;
    end else if (cp < 21'h800) begin
      u[0] = 8'hC0 | 8'(cp >> 6);
      u[1] = 8'h80 | 8'(cp & 21'h3F);
      n = 2;
    end else if (cp < 21'h10000) begin
      u[0] = 8'hE0 | 8'(cp >> 12);
      u[1] = 8'h80 | 8'((cp >> 6) & 21'h3F);
      u[2] = 8'h80 | 8'(cp & 21'h3F);
      n = 3;
    end else begin
      u[0] = 8'hF0 | 8'(cp >> 18);
      u[1] = 8'h80 | 8'((cp >> 12) & 21'h3F);
      u[2] = 8'h80 | 8'((cp >> 6) & 21'h3F);
      u[3] = 8'h80 | 8'(cp & 21'h3F);
      n = 4;
    end
    if (17'(emitted) + 17'(n) <= 17'(byte_limit)) begin
      for (int i = 0; i < n; i++) note(u[i], KIND_DATA);
      emitted = emitted + 16'(n);
    end
  endfunction

  function automatic int nib_of(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
    if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
    return -1;
  endfunction

  // Partial \u digits go back out as the raw characters, oldest first.
  function automatic void flush_hex();
    int n;
    n = (hex_cnt > 3'd3) ? 3 : int'(hex_cnt);
    for (int i = 0; i < n; i++) emit_data(8'(hex_chars >> (8 * (n - 1 - i))));
    clear_hex();
  endfunction

  function automatic void in_string(logic [7:0] c);
    if (c == CH_QUOTE) begin
      note(8'h00, KIND_CLOSED);
      dec_mode = MODE_IDLE;
    end else if (c == CH_BSLASH) begin
      dec_mode = MODE_ESC;
    end else begin
      emit_data(c);
    end
  endfunction

  function automatic void escaped(logic [7:0] c);
    logic [7:0] v;
    if (c == CH_U) begin
      clear_hex();
      dec_mode = MODE_HEX;
      return;
    end
    case (c)
      CH_N:    v = 8'h0A;
      CH_T:    v = 8'h09;
      CH_R:    v = 8'h0D;
      CH_B:    v = 8'h08;
      CH_F:    v = 8'h0C;
      default: v = c;
    endcase
    emit_data(v);
    dec_mode = MODE_STR;
  endfunction

  // A completed \u code: high surrogates wait for a partner.
  function automatic void take_unit(logic [15:0] cp);
    clear_hex();
    if (cp >= 16'hD800 && cp <= 16'hDBFF) begin
      held_hi  = cp;
      dec_mode = MODE_HIBS;
    end else begin
      emit_cp(21'(cp));
      dec_mode = MODE_STR;
    end
  endfunction

  function automatic bit push_digit(logic [7:0] c, int v);
    hex_code  = {hex_code[11:0], 4'(v)};
    hex_chars = {hex_chars[15:0], c};
    hex_cnt   = hex_cnt + 3'd1;
    return hex_cnt >= 3'd4;
  endfunction

  // Decode one accepted byte and queue the results it owes.
  function automatic void unescape_byte(logic [7:0] c, logic eob);
    int          v;
    logic [15:0] lo;
    step_out.delete();
    case (dec_mode)
      MODE_IDLE: begin
        if (c == CH_QUOTE) begin
          dec_mode = MODE_STR;
          emitted  = 16'h0000;
          clear_hex();
          held_hi  = 16'h0000;
        end else begin
          note(8'h00, KIND_NO_STRING);
        end
      end
      MODE_STR: in_string(c);
      MODE_ESC: escaped(c);
      MODE_HEX: begin
        v = nib_of(c);
        if (v < 0) begin
          flush_hex();
          dec_mode = MODE_STR;
          in_string(c);
        end else if (push_digit(c, v)) begin
          take_unit(hex_code);
        end
      end
      MODE_HIBS: begin
        if (c == CH_BSLASH) begin
          dec_mode = MODE_HIU;
        end else begin
          emit_cp(21'(held_hi));
          dec_mode = MODE_STR;
          in_string(c);
        end
      end
      MODE_HIU: begin
        if (c == CH_U) begin
          clear_hex();
          dec_mode = MODE_LOHEX;
        end else begin
          emit_cp(21'(held_hi));
          escaped(c);
        end
      end
      MODE_LOHEX: begin
        v = nib_of(c);
        if (v < 0) begin
          emit_cp(21'(held_hi));
          flush_hex();
          dec_mode = MODE_STR;
          in_string(c);
        end else if (push_digit(c, v)) begin
          lo = hex_code;
          if (lo >= 16'hDC00 && lo <= 16'hDFFF) begin
            emit_cp(21'h10000 + {1'b0, held_hi[9:0], 10'b0} + 21'(lo[9:0]));
            clear_hex();
            dec_mode = MODE_STR;
          end else begin
            emit_cp(21'(held_hi));
            take_unit(lo);
          end
        end
      end
      default: dec_mode = MODE_IDLE;
    endcase

    // Buffer ends inside a string: flush whatever is pending, then report.
    if (eob && dec_mode != MODE_IDLE) begin
      case (dec_mode)
        MODE_ESC:   emit_data(CH_BSLASH);
        MODE_HEX:   flush_hex();
        MODE_HIBS:  emit_cp(21'(held_hi));
        MODE_HIU: begin
          emit_cp(21'(held_hi));
          emit_data(CH_BSLASH);
        end
        MODE_LOHEX: begin
          emit_cp(21'(held_hi));
          flush_hex();
        end
        default: ;
      endcase
      note(8'h00, KIND_UNTERM);
      clear_hex();
      dec_mode = MODE_IDLE;
    end

    if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
    foreach (step_out[i]) expected_out.push_back(step_out[i]);
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------
  function automatic void add_byte(logic [7:0] d, logic eob);
    src_item_t it;
    it.data = d;
    it.eob  = eob;
    src_bytes.push_back(it);
  endfunction

  function automatic void add_text(string s, logic eob_last);
    for (int i = 0; i < s.len(); i++) add_byte(8'(s[i]), eob_last && (i == s.len() - 1));
  endfunction

  function automatic logic [7:0] rand_byte_except(logic [7:0] a, logic [7:0] b);
    logic [7:0] r;
    do r = 8'($urandom); while (r == a || r == b);
    return r;
  endfunction

  function automatic logic [7:0] rand_non_hex();
    logic [7:0] r;
    do r = 8'($urandom); while (nib_of(r) >= 0);
    return r;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
  endfunction

  // Codes by class: 1, 2 and 3 byte UTF-8, high and low surrogates, edges.
  function automatic logic [15:0] rand_code(int cls);
    case (cls)
      0: return 16'($urandom_range(0, 16'h7F));
      1: return 16'($urandom_range(16'h80, 16'h7FF));
      2: begin
        if ($urandom_range(0, 1)) return 16'($urandom_range(16'h800, 16'hD7FF));
        return 16'($urandom_range(16'hE000, 16'hFFFF));
      end
      3: return 16'($urandom_range(16'hD800, 16'hDBFF));
      4: return 16'($urandom_range(16'hDC00, 16'hDFFF));
      default: begin
        case ($urandom_range(0, 7))
          0: return 16'h0000;
          1: return 16'hFFFF;
          2: return 16'hD800;
          3: return 16'hDFFF;
          4: return 16'h007F;
          5: return 16'h0080;
          6: return 16'h07FF;
          default: return 16'h0800;
        endcase
      end
    endcase
  endfunction

  function automatic logic [7:0] rand_escape();
    case ($urandom_range(0, 9))
      0: return CH_QUOTE;
      1: return CH_BSLASH;
      2: return CH_SLASH;
      3: return CH_N;
      4: return CH_T;
      5: return CH_R;
      6: return CH_B;
      7: return CH_F;
      default: return rand_byte_except(CH_U, CH_U);
    endcase
  endfunction

  function automatic void push_u(logic [15:0] code);
    tok.push_back(CH_BSLASH);
    tok.push_back(CH_U);
    tok.push_back(hex_char(code[15:12]));
    tok.push_back(hex_char(code[11:8]));
    tok.push_back(hex_char(code[7:4]));
    tok.push_back(hex_char(code[3:0]));
  endfunction

  // \u with fewer than four digits and then a non-hex byte.
  function automatic void push_broken_u();
    tok.push_back(CH_BSLASH);
    tok.push_back(CH_U);
    repeat ($urandom_range(0, 3)) tok.push_back(hex_char(4'($urandom)));
    tok.push_back(rand_non_hex());
  endfunction

  function automatic void add_token();
    logic [15:0] cp;
    case ($urandom_range(0, 9))
      0, 1: tok.push_back(rand_byte_except(CH_QUOTE, CH_BSLASH));
      2: begin
        tok.push_back(CH_BSLASH);
        tok.push_back(rand_escape());
      end
      3, 4: push_u(rand_code($urandom_range(0, 5)));
      5: begin
        push_u(rand_code(3));
        push_u(rand_code(4));
      end
      6: begin
        // high surrogate whose partner never shows up properly
        push_u(rand_code(3));
        case ($urandom_range(0, 3))
          0: tok.push_back(rand_byte_except(CH_BSLASH, CH_BSLASH));
          1: begin
            tok.push_back(CH_BSLASH);
            tok.push_back(rand_byte_except(CH_U, CH_U));
          end
          2: begin
            do cp = rand_code($urandom_range(0, 5)); while (cp >= 16'hDC00 && cp <= 16'hDFFF);
            push_u(cp);
          end
          default: push_broken_u();
        endcase
      end
      7: push_broken_u();
      8: push_u(rand_code(4));
      default: tok.push_back(8'($urandom));
    endcase
  endfunction

  // A quoted string of random tokens, either closed or cut off by the
  // end of the buffer at any point, sometimes preceded by stray bytes.
  function automatic void add_random_string();
    int cut;
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3))
        add_byte(rand_byte_except(CH_QUOTE, CH_QUOTE), $urandom_range(0, 3) == 0);
    end
    if ($urandom_range(0, 19) == 0) begin
      add_byte(CH_QUOTE, 1'b1);
      return;
    end
    tok.delete();
    repeat ($urandom_range(1, 6)) add_token();
    add_byte(CH_QUOTE, 1'b0);
    if ($urandom_range(0, 9) < 6) begin
      foreach (tok[i]) add_byte(tok[i], 1'b0);
      add_byte(CH_QUOTE, $urandom_range(0, 3) == 0);
    end else begin
      cut = $urandom_range(1, tok.size());
      for (int i = 0; i < cut; i++) add_byte(tok[i], i == cut - 1);
    end
  endfunction

  // Wait until every request went in and every result came out, then
  // give bytes that owe nothing time to leave the pipeline.
  task automatic settle();
    while (!(src_bytes.size() == 0 && !drv_valid && expected_out.size() == 0))
      @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_limit(logic [15:0] v);
    @(negedge clk);
    cfg_en   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_en   <= 1'b0;
    byte_limit = v;
  endtask

  // ---------------------------------------------------------------------
  // Input driver: a request is taken at a rising edge with valid and
  // ready high; the next one (or an idle burst) is set up at the
  // following falling edge.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    in_took = rst_n && drv_valid && in_if.ready;
    if (in_took) unescape_byte(drv_byte, drv_eob);
  end

  always @(negedge clk) begin : drive_in
    src_item_t nxt;
    if (!rst_n) begin
      drv_valid <= 1'b0;
    end else if (!drv_valid || in_took) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        drv_valid <= 1'b0;
      end else if (src_bytes.size() > 0 && !calm && $urandom_range(0, 4) == 0) begin
        gap_left = $urandom_range(1, 13) - 1;
        drv_valid <= 1'b0;
      end else if (src_bytes.size() > 0) begin
        nxt = src_bytes.pop_front();
        drv_byte  <= nxt.data;
        drv_eob   <= nxt.eob;
        drv_valid <= 1'b1;
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure: random stall bursts, none once calm.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      sink_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 6) == 0) begin
      stall_left = $urandom_range(1, 13) - 1;
      sink_ready <= 1'b0;
    end else begin
      sink_ready <= 1'b1;
    end
  end

  // Every accepted result must match the oldest one still owed.
  always @(posedge clk) begin : check_out
    out_rec_t want;
    if (rst_n && out_if.valid && sink_ready) begin
      if (expected_out.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10)
          $display("unexpected result: byte %02h kind %0d last %0d",
                   out_if.out_byte, out_if.kind, out_if.last);
      end else begin
        want = expected_out.pop_front();
        if (out_if.out_byte !== want.b || out_if.kind !== want.k ||
            out_if.last !== want.last) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display({"mismatch: expected byte %02h kind %0d last %0d, ",
                      "got byte %02h kind %0d last %0d"},
                     want.b, want.k, want.last, out_if.out_byte, out_if.kind, out_if.last);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin : stimulus
    logic [15:0] lim_list [8];
    reset_model();
    lim_list = '{16'd0, 16'd1, 16'd3, 16'd5, 16'hFFFF, 16'd2,
                 16'($urandom_range(4, 24)), MAX_OUT_RST};
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: stray bytes while idle (zero and all-ones, the latter at
    // buffer end), buffer end on an opening quote, escapes, a surrogate
    // pair at the top of the range and a close, then a bad hex digit and
    // a trailing backslash at buffer end.
    write_limit(16'hFFFF);
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b1);
    add_byte(CH_QUOTE, 1'b1);
    add_text("\"\\n\\uDBFF\\uDFFF\"", 1'b0);
    add_text("\"\\u4g\\", 1'b1);
    add_byte(CH_QUOTE, 1'b1);
    settle();

    // Random phases, each under its own output limit; each ends with a
    // quote at buffer end so the decoder is idle before the next write.
    for (int ph = 0; ph < 8; ph++) begin
      write_limit(lim_list[ph]);
      if (ph == 7) calm = 1'b1;
      while (src_bytes.size() < 30) add_random_string();
      add_byte(CH_QUOTE, 1'b1);
      settle();
    end

    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5000000;
    $display("tb_top failed");
    $finish;
  end

endmodule
